[src/stkt_pkg.sv]
package stkt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_CHARS     = 8;
    localparam int KEY_W         = 64;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = 4;
    localparam int PRINT_N       = (TABLE_ENTRIES < 16) ? TABLE_ENTRIES : 16;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [KEY_W-1:0]  t_key;

    localparam t_addr LAST_ADDR  = t_addr'(TABLE_ENTRIES - 1);
    localparam t_addr PRINT_LAST = t_addr'(PRINT_N - 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_PRINT  = 3'd4;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_SORTED   = 3'd6;
    localparam logic [2:0] ST_ENTRY    = 3'd7;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_key  wr_data;
    } t_ram_req;

endpackage

[src/stkt_key_ram.sv]
module stkt_key_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stkt_pkg::t_ram_req i_req,
    output stkt_pkg::t_key     o_rd_data
);

    stkt_pkg::t_key                         mem [stkt_pkg::TABLE_ENTRIES];
    logic [stkt_pkg::TABLE_ENTRIES-1:0]     r_vld;
    stkt_pkg::t_key                         r_rd_data;
    logic                                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
        end
    end

    // A slot never written since reset reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[src/string_key_table.sv]
// Table of sixteen 64-bit text keys held in a one-read, one-write memory with a
// registered read. Per-slot valid flags cleared by reset make every slot read as
// empty, so there is no clearing pass. One command item is taken at a time;
// the memory read port, walking one slot per cycle, sets the timing. Add,
// search and remove scan all slots and return one result once the last slot has
// been checked. Sort is a selection sort through the same port. Print returns
// sixteen entry items, the last one with tlast set; each slot is read only once
// the item before it has been sent. Op codes 5 to 7 are dropped with no result.
// Output stalls hold the block in its result and print steps.
module string_key_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[63:0]
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // slot[3:0], entry_key[67:4], zero[71:68]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_FINISH    = 4'd2;
    localparam logic [3:0] S_SORT      = 4'd3;
    localparam logic [3:0] S_SORT_WB   = 4'd4;
    localparam logic [3:0] S_SORT_DONE = 4'd5;
    localparam logic [3:0] S_PRINT_RD  = 4'd6;
    localparam logic [3:0] S_PRINT_DAT = 4'd7;
    localparam logic [3:0] S_PRINT_OUT = 4'd8;

    // A key ends at its first zero byte, and only KEY_CHARS characters count.
    function automatic stkt_pkg::t_key f_norm(input stkt_pkg::t_key k);
        logic           alive;
        logic [7:0]     b;
        stkt_pkg::t_key res;
        alive = 1'b1;
        res   = '0;
        for (int i = 0; i < 8; i++) begin
            b = k[63-8*i -: 8];
            if (i >= stkt_pkg::KEY_CHARS || b == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[63-8*i -: 8] = b;
            end
        end
        return res;
    endfunction

    logic [3:0]         r_state, n_state;
    logic [2:0]         r_op, n_op;
    stkt_pkg::t_key     r_key, n_key;
    stkt_pkg::t_addr    r_addr, n_addr;
    logic               r_iss_done, n_iss_done;
    logic               r_rd_pend, n_rd_pend;
    stkt_pkg::t_addr    r_rd_addr, n_rd_addr;
    logic               r_hit, n_hit;
    stkt_pkg::t_addr    r_hit_idx, n_hit_idx;
    logic               r_emp, n_emp;
    stkt_pkg::t_addr    r_emp_idx, n_emp_idx;
    stkt_pkg::t_addr    r_i, n_i;
    stkt_pkg::t_key     r_a, n_a;
    logic               r_first, n_first;
    logic               r_m_valid, n_m_valid;
    logic [2:0]         r_m_status, n_m_status;
    stkt_pkg::t_slot    r_m_slot, n_m_slot;
    stkt_pkg::t_key     r_m_key, n_m_key;
    logic               r_m_last, n_m_last;

    stkt_pkg::t_ram_req ram_req;
    stkt_pkg::t_key     rd_data;
    logic               out_free;

    stkt_key_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_addr     = r_addr;
        n_iss_done = r_iss_done;
        n_rd_pend  = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_emp      = r_emp;
        n_emp_idx  = r_emp_idx;
        n_i        = r_i;
        n_a        = r_a;
        n_first    = r_first;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_status = r_m_status;
        n_m_slot   = r_m_slot;
        n_m_key    = r_m_key;
        n_m_last   = r_m_last;

        ram_req         = '0;
        ram_req.rd_addr = r_addr;
        ram_req.wr_addr = r_rd_addr;
        ram_req.wr_data = r_a;

        // Scan and sort stream one read per cycle until the last slot is issued.
        if ((r_state == S_SCAN || r_state == S_SORT) && !r_iss_done) begin
            ram_req.rd_en = 1'b1;
            n_rd_pend     = 1'b1;
            n_rd_addr     = r_addr;
            n_addr        = r_addr + 1'b1;
            if (r_addr == stkt_pkg::LAST_ADDR) begin
                n_iss_done = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op       = s_axis_tuser;
                    n_key      = f_norm(s_axis_tdata);
                    n_addr     = '0;
                    n_iss_done = 1'b0;
                    n_hit      = 1'b0;
                    n_emp      = 1'b0;
                    n_first    = 1'b1;
                    n_i        = '0;
                    case (s_axis_tuser)
                        stkt_pkg::OP_ADD,
                        stkt_pkg::OP_SEARCH,
                        stkt_pkg::OP_REMOVE: n_state = S_SCAN;
                        stkt_pkg::OP_SORT:   n_state = S_SORT;
                        stkt_pkg::OP_PRINT:  n_state = S_PRINT_RD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_pend) begin
                    if (!r_hit && rd_data == r_key) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rd_addr;
                    end
                    if (!r_emp && rd_data == '0) begin
                        n_emp     = 1'b1;
                        n_emp_idx = r_rd_addr;
                    end
                    if (r_rd_addr == stkt_pkg::LAST_ADDR) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_last   = 1'b1;
                    n_m_key    = '0;
                    n_m_slot   = '0;
                    n_m_status = stkt_pkg::ST_NOTFOUND;
                    n_state    = S_IDLE;
                    case (r_op)
                        stkt_pkg::OP_ADD: begin
                            if (r_hit) begin
                                n_m_status = stkt_pkg::ST_PRESENT;
                                n_m_slot   = stkt_pkg::t_slot'(r_hit_idx);
                            end else if (r_emp) begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = r_emp_idx;
                                ram_req.wr_data = r_key;
                                n_m_status      = stkt_pkg::ST_ADDED;
                                n_m_slot        = stkt_pkg::t_slot'(r_emp_idx);
                            end else begin
                                n_m_status = stkt_pkg::ST_FULL;
                            end
                        end
                        stkt_pkg::OP_SEARCH: begin
                            if (r_hit) begin
                                n_m_status = stkt_pkg::ST_FOUND;
                                n_m_slot   = stkt_pkg::t_slot'(r_hit_idx);
                            end
                        end
                        stkt_pkg::OP_REMOVE: begin
                            if (r_hit) begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = r_hit_idx;
                                ram_req.wr_data = '0;
                                n_m_status      = stkt_pkg::ST_REMOVED;
                                n_m_slot        = stkt_pkg::t_slot'(r_hit_idx);
                            end
                        end
                        default: begin
                            n_m_status = stkt_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_SORT: begin
                // The first word read is slot i; each later word is swapped
                // with the carried minimum when smaller.
                if (r_rd_pend) begin
                    if (r_first) begin
                        n_a     = rd_data;
                        n_first = 1'b0;
                    end else if (r_a > rd_data) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = r_rd_addr;
                        ram_req.wr_data = r_a;
                        n_a             = rd_data;
                    end
                    if (r_rd_addr == stkt_pkg::LAST_ADDR) begin
                        n_state = S_SORT_WB;
                    end
                end
            end
            S_SORT_WB: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_i;
                ram_req.wr_data = r_a;
                if (r_i == stkt_pkg::LAST_ADDR - 1'b1) begin
                    n_state = S_SORT_DONE;
                end else begin
                    n_i        = r_i + 1'b1;
                    n_addr     = r_i + 1'b1;
                    n_first    = 1'b1;
                    n_iss_done = 1'b0;
                    n_state    = S_SORT;
                end
            end
            S_SORT_DONE: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_last   = 1'b1;
                    n_m_key    = '0;
                    n_m_slot   = '0;
                    n_m_status = stkt_pkg::ST_SORTED;
                    n_state    = S_IDLE;
                end
            end
            S_PRINT_RD: begin
                ram_req.rd_en = 1'b1;
                n_rd_pend     = 1'b1;
                n_state       = S_PRINT_DAT;
            end
            S_PRINT_DAT, S_PRINT_OUT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = stkt_pkg::ST_ENTRY;
                    n_m_slot   = stkt_pkg::t_slot'(r_addr);
                    n_m_key    = (r_state == S_PRINT_DAT) ? rd_data : r_a;
                    n_m_last   = (r_addr == stkt_pkg::PRINT_LAST);
                    if (r_addr == stkt_pkg::PRINT_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = S_PRINT_RD;
                    end
                end else if (r_state == S_PRINT_DAT) begin
                    n_a     = rd_data;
                    n_state = S_PRINT_OUT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_addr     <= n_addr;
        r_iss_done <= n_iss_done;
        r_rd_addr  <= n_rd_addr;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_emp      <= n_emp;
        r_emp_idx  <= n_emp_idx;
        r_i        <= n_i;
        r_a        <= n_a;
        r_first    <= n_first;
        r_m_status <= n_m_status;
        r_m_slot   <= n_m_slot;
        r_m_key    <= n_m_key;
        r_m_last   <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {4'b0000, r_m_key, r_m_slot};

    // The memory never reads and writes the same slot in one cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.rd_en && ram_req.wr_en |-> ram_req.rd_addr != ram_req.wr_addr)
        else $error("memory read and write hit the same slot");

    // No read is left in flight once the block is ready again.
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_rd_pend)
        else $error("read pending while idle");

    // Every result other than a print entry closes its command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != stkt_pkg::ST_ENTRY |-> m_axis_tlast)
        else $error("single result without tlast");

    // A command with a known op code keeps the block busy in the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == stkt_pkg::OP_ADD || s_axis_tuser == stkt_pkg::OP_SEARCH ||
         s_axis_tuser == stkt_pkg::OP_REMOVE || s_axis_tuser == stkt_pkg::OP_SORT ||
         s_axis_tuser == stkt_pkg::OP_PRINT) |=> !s_axis_tready)
        else $error("command accepted but block not busy");

endmodule
